// File: hw/rtl/stepper_ramp_motion_controller_top_defines.svh
// assertion macros for the stepper ramp controller
`ifndef STEPPER_RAMP_MOTION_CONTROLLER_TOP_DEFINES_SVH
`define STEPPER_RAMP_MOTION_CONTROLLER_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SRMC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define SRMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/srmc_pkg.sv
// shared types and constants for the stepper ramp controller
package srmc_pkg;

    localparam logic [1:0] CMD_TICK      = 2'd0;
    localparam logic [1:0] CMD_SET_GOAL  = 2'd1;
    localparam logic [1:0] CMD_SET_STOP  = 2'd2;
    localparam logic [1:0] CMD_SET_STEPS = 2'd3;

    localparam logic [1:0] MODE_STOP  = 2'd0;
    localparam logic [1:0] MODE_ACCEL = 2'd1;
    localparam logic [1:0] MODE_RUN   = 2'd2;
    localparam logic [1:0] MODE_DECEL = 2'd3;

    localparam int DIV_W = 40;
    localparam int DIV_STEPS = 40;
    localparam logic [15:0] PERIOD_MAX = 16'hffff;

    // divider operand selection
    typedef enum logic [2:0] {
        DSEL_STEPS,
        DSEL_RAMP,
        DSEL_LEFT,
        DSEL_RIGHT,
        DSEL_FREQ,
        DSEL_BRAKE
    } dsel_t;

    typedef struct packed {
        logic  load_in;
        logic  div_start;
        dsel_t div_sel;
        logic  do_count;
        logic  do_ramp;
        logic  do_steer;
        logic  do_brake_mul;
        logic  do_brake;
        logic  do_finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic div_busy;
    } ctl_stat_t;

endpackage

// File: hw/rtl/stepper_ramp_motion_controller_top.sv
// a tick outside stop mode runs five divider passes and a braking step, then the state update
// set commands and stop-mode ticks go straight to the state update; the result then waits until taken
// one request at a time; the next request is taken the cycle after the result leaves;
// the shared divider sets the pace of a tick
// rst_n is asynchronous, active low; it clears the mode, counters, steering periods and duty_offset
`include "stepper_ramp_motion_controller_top_defines.svh"
module stepper_ramp_motion_controller_top
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        cmd,
    input  logic [31:0]       value,
    input  logic signed [7:0] steer_pct,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        mode,
    output logic              motors_on,
    output logic [15:0]       common_period,
    output logic [15:0]       left_period,
    output logic [15:0]       right_period,
    output logic [15:0]       left_duty,
    output logic [15:0]       right_duty,
    output logic              distance_event,
    output logic [31:0]       steps_to_stop
);
    localparam logic [1:0] ADDR_DUTY = 2'd0;

    logic [15:0] duty_reg;
    srmc_pkg::ctl_cmd_t  ctl;
    srmc_pkg::ctl_stat_t stat;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_DUTY) ? {16'd0, duty_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            duty_reg <= '0;
        else if (psel && penable && pwrite && paddr == ADDR_DUTY)
            duty_reg <= pwdata[15:0];
    end

    srmc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (cmd),
        .cur_mode  (mode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    srmc_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .cmd            (cmd),
        .value          (value),
        .steer_pct      (steer_pct),
        .duty_offset    (duty_reg),
        .mode           (mode),
        .motors_on      (motors_on),
        .common_period  (common_period),
        .left_period    (left_period),
        .right_period   (right_period),
        .left_duty      (left_duty),
        .right_duty     (right_duty),
        .distance_event (distance_event),
        .steps_to_stop  (steps_to_stop)
    );

    `SRMC_ASSERT_IMP(a_no_take_while_out, out_valid, in_stall, "request taken while result pending")
    `SRMC_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid && $stable(common_period), "stalled result changed")
    `SRMC_ASSERT_IMP(a_stop_drivers_off, out_valid && mode == srmc_pkg::MODE_STOP && $past(mode) != srmc_pkg::MODE_STOP, !motors_on, "stop with drivers on")
endmodule

// File: hw/rtl/srmc_divider.sv
// iterative restoring divider, one quotient bit per cycle
module srmc_divider
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [srmc_pkg::DIV_W-1:0]   dividend,
    input  logic [srmc_pkg::DIV_W-1:0]   divisor,
    output logic                         busy,
    output logic [srmc_pkg::DIV_W-1:0]   quotient
);
    localparam int W = srmc_pkg::DIV_W;
    localparam int CW = $clog2(srmc_pkg::DIV_STEPS + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]    trial;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        trial = {rem_reg, quo_reg[W-1]} - {1'b0, den_reg};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
            cnt_next = CW'(srmc_pkg::DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = (cnt_reg != '0);
    assign quotient = quo_reg;
endmodule

// File: hw/rtl/srmc_datapath.sv
// state registers, shared divider and result registers of the ramp controller
module srmc_datapath
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  srmc_pkg::ctl_cmd_t         ctl,
    output srmc_pkg::ctl_stat_t        stat,
    input  logic [1:0]                 cmd,
    input  logic [31:0]                value,
    input  logic signed [7:0]          steer_pct,
    input  logic [15:0]                duty_offset,
    output logic [1:0]                 mode,
    output logic                       motors_on,
    output logic [15:0]                common_period,
    output logic [15:0]                left_period,
    output logic [15:0]                right_period,
    output logic [15:0]                left_duty,
    output logic [15:0]                right_duty,
    output logic                       distance_event,
    output logic [31:0]                steps_to_stop
);
    localparam int W = srmc_pkg::DIV_W;

    logic [1:0]  cmd_reg;
    logic [31:0] val_reg;
    logic signed [7:0] lock_reg;
    logic [1:0]  mode_reg, mode_next;
    logic [15:0] ramp_reg, ramp_next;
    logic [15:0] pnow_reg, pnow_next;
    logic [15:0] pgoal_reg, pgoal_next;
    logic [15:0] lper_reg, lper_next;
    logic [15:0] rper_reg, rper_next;
    logic [31:0] brake_reg, brake_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] sgoal_reg, sgoal_next;
    logic [31:0] stopl_reg, stopl_next;
    logic        drv_reg, drv_next;
    logic        ev_reg, ev_next;
    logic [31:0] ns_reg, ns_next;
    logic [19:0] q_reg, q_next;
    logic [39:0] qsq_reg, qsq_next;
    logic [12:0] q1_reg, q1_next;
    logic [5:0]  r1_reg, r1_next;

    logic         div_busy;
    logic [W-1:0] div_q;
    logic [W-1:0] dend, dsor;
    logic [15:0]  psafe;
    logic signed [7:0] lock_c;
    logic [7:0]   lsum, rsum;
    logic [31:0]  total_add;
    logic [16:0]  pdec;
    logic signed [17:0] diff_ag, diff_ga, tol;
    logic [32:0]  tol_prod;
    logic [36:0]  m1_prod;
    logic [17:0]  r1_full;
    logic [22:0]  b_lo;
    logic [45:0]  m2_prod;
    logic [29:0]  brake_q;

    assign psafe = (pnow_reg == '0) ? 16'd1 : pnow_reg;
    assign lock_c = (lock_reg > 8'sd99) ? 8'sd99 :
                    (lock_reg < -8'sd99) ? -8'sd99 : lock_reg;
    assign lsum = 8'(8'sd100 + lock_c);
    assign rsum = 8'(8'sd100 - lock_c);

    always_comb
    begin
        dend = '0;
        dsor = W'(1);
        case (ctl.div_sel)
            srmc_pkg::DSEL_STEPS: begin dend = W'(10000); dsor = W'(psafe); end
            srmc_pkg::DSEL_RAMP:  begin dend = W'(pnow_reg); dsor = W'({1'b0, ramp_reg} + 17'd2); end
            srmc_pkg::DSEL_LEFT:  begin dend = W'(pnow_reg) * W'(100); dsor = W'(lsum); end
            srmc_pkg::DSEL_RIGHT: begin dend = W'(pnow_reg) * W'(100); dsor = W'(rsum); end
            srmc_pkg::DSEL_FREQ:  begin dend = W'(1000000); dsor = W'(psafe); end
            default:              begin dend = '0; dsor = W'(1); end
        endcase
    end

    srmc_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (dend),
        .divisor  (dsor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign stat.div_busy = div_busy;

    // braking distance q*q/1568: drop 5 bits, then divide by 49 in two
    // reciprocal steps, high 18 bits first, remainder carried into the low part
    assign m1_prod = 37'(qsq_reg[39:22]) * 37'(19'd342393);
    assign q1_next = m1_prod[36:24];
    assign r1_full = qsq_reg[39:22] - ({5'd0, q1_next} * 18'd49);
    assign r1_next = r1_full[5:0];
    assign b_lo = {r1_reg, qsq_reg[21:5]};
    assign m2_prod = 46'(b_lo) * 46'(23'd5478275);
    assign brake_q = {q1_reg, m2_prod[44:28]};

    assign total_add = total_reg + div_q[31:0];
    assign pdec = {1'b0, pnow_reg} + 17'(div_q[15:0]);
    assign diff_ag = $signed({2'b0, pnow_reg}) - $signed({2'b0, pgoal_reg});
    assign diff_ga = $signed({2'b0, pgoal_reg}) - $signed({2'b0, pnow_reg});
    // goal/50 by reciprocal multiplication
    assign tol_prod = 33'(pgoal_reg) * 33'(17'd83887);
    assign tol = $signed({7'b0, tol_prod[32:22]});

    always_comb
    begin
        mode_next = mode_reg;
        ramp_next = ramp_reg;
        pnow_next = pnow_reg;
        pgoal_next = pgoal_reg;
        lper_next = lper_reg;
        rper_next = rper_reg;
        brake_next = brake_reg;
        total_next = total_reg;
        sgoal_next = sgoal_reg;
        stopl_next = stopl_reg;
        drv_next = drv_reg;
        ev_next = ev_reg;
        ns_next = ns_reg;
        q_next = q_reg;
        qsq_next = qsq_reg;
        if (ctl.load_in)
        begin
            ev_next = 1'b0;
            // ramp counter steps before its division
            if (cmd == srmc_pkg::CMD_TICK && mode_reg == srmc_pkg::MODE_ACCEL
                && ramp_reg != 16'hffff)
                ramp_next = ramp_reg + 16'd1;
            else if (cmd == srmc_pkg::CMD_TICK && mode_reg == srmc_pkg::MODE_DECEL
                && ramp_reg != 16'd0)
                ramp_next = ramp_reg - 16'd1;
        end
        if (ctl.do_count)
        begin
            ns_next = div_q[31:0];
            total_next = total_add;
            if (sgoal_reg != '0 && total_add >= sgoal_reg)
            begin
                ev_next = 1'b1;
                total_next = '0;
                sgoal_next = '0;
            end
            if (stopl_reg > brake_reg)
                stopl_next = (stopl_reg > ns_next) ? stopl_reg - ns_next : '0;
        end
        if (ctl.do_ramp)
        begin
            if (mode_reg == srmc_pkg::MODE_ACCEL)
                pnow_next = pnow_reg - div_q[15:0];
            else
                pnow_next = pdec[16] ? 16'hffff : pdec[15:0];
        end
        if (ctl.do_steer)
        begin
            if (ctl.div_sel == srmc_pkg::DSEL_LEFT)
                lper_next = (div_q > W'(16'hffff)) ? 16'hffff : div_q[15:0];
            else
                rper_next = (div_q > W'(16'hffff)) ? 16'hffff : div_q[15:0];
        end
        if (ctl.do_brake_mul)
        begin
            q_next = div_q[19:0];
            qsq_next = 40'(q_next) * 40'(q_next);
        end
        if (ctl.do_brake)
            brake_next = {2'b0, brake_q};
        if (ctl.do_finish)
        begin
            unique case (cmd_reg)
                srmc_pkg::CMD_SET_GOAL:  pgoal_next = val_reg[15:0];
                srmc_pkg::CMD_SET_STOP:  stopl_next = val_reg;
                srmc_pkg::CMD_SET_STEPS: sgoal_next = val_reg;
                srmc_pkg::CMD_TICK:
                begin
                    unique case (mode_reg)
                        srmc_pkg::MODE_STOP:
                        begin
                            if (pgoal_reg < 16'hffff)
                            begin
                                mode_next = srmc_pkg::MODE_ACCEL;
                                drv_next = 1'b1;
                            end
                        end
                        srmc_pkg::MODE_ACCEL, srmc_pkg::MODE_RUN:
                        begin
                            if (mode_reg == srmc_pkg::MODE_ACCEL)
                            begin
                                if (pnow_reg <= pgoal_reg)
                                    mode_next = srmc_pkg::MODE_RUN;
                            end
                            else if (diff_ag > tol)
                                mode_next = srmc_pkg::MODE_ACCEL;
                            else if (diff_ga > tol)
                                mode_next = srmc_pkg::MODE_DECEL;
                            if (stopl_reg != '0 && brake_reg >= stopl_reg)
                            begin
                                pgoal_next = 16'hffff;
                                mode_next = srmc_pkg::MODE_DECEL;
                            end
                        end
                        srmc_pkg::MODE_DECEL:
                        begin
                            if (ramp_reg <= 16'd1)
                            begin
                                mode_next = srmc_pkg::MODE_STOP;
                                drv_next = 1'b0;
                                stopl_next = '0;
                            end
                            else if (pnow_reg >= pgoal_reg)
                                mode_next = srmc_pkg::MODE_RUN;
                        end
                        default: mode_next = mode_reg;
                    endcase
                end
                default: mode_next = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= srmc_pkg::MODE_STOP;
            ramp_reg <= '0;
            pnow_reg <= srmc_pkg::PERIOD_MAX;
            pgoal_reg <= srmc_pkg::PERIOD_MAX;
            lper_reg <= '0;
            rper_reg <= '0;
            brake_reg <= '0;
            total_reg <= '0;
            sgoal_reg <= '0;
            stopl_reg <= '0;
            drv_reg <= 1'b0;
            ev_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            ramp_reg <= ramp_next;
            pnow_reg <= pnow_next;
            pgoal_reg <= pgoal_next;
            lper_reg <= lper_next;
            rper_reg <= rper_next;
            brake_reg <= brake_next;
            total_reg <= total_next;
            sgoal_reg <= sgoal_next;
            stopl_reg <= stopl_next;
            drv_reg <= drv_next;
            ev_reg <= ev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ns_reg <= ns_next;
        q_reg <= q_next;
        qsq_reg <= qsq_next;
        q1_reg <= q1_next;
        r1_reg <= r1_next;
        if (ctl.load_in)
        begin
            cmd_reg <= cmd;
            val_reg <= value;
            lock_reg <= steer_pct;
        end
    end

    assign mode = mode_reg;
    assign motors_on = drv_reg;
    assign common_period = pnow_reg;
    assign left_period = lper_reg;
    assign right_period = rper_reg;
    assign left_duty = (lper_reg > duty_offset) ? lper_reg - duty_offset : '0;
    assign right_duty = (rper_reg > duty_offset) ? rper_reg - duty_offset : '0;
    assign distance_event = ev_reg;
    assign steps_to_stop = stopl_reg;
endmodule

// File: hw/rtl/srmc_ctrl.sv
// sequencer for one request: divider passes for a running tick, then state update and result
module srmc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [1:0]            in_cmd,
    input  logic [1:0]            cur_mode,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  srmc_pkg::ctl_stat_t   stat,
    output srmc_pkg::ctl_cmd_t    ctl
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_STEPS  = 4'd1;
    localparam logic [3:0] S_RAMP   = 4'd2;
    localparam logic [3:0] S_LEFT   = 4'd3;
    localparam logic [3:0] S_RIGHT  = 4'd4;
    localparam logic [3:0] S_FREQ   = 4'd5;
    localparam logic [3:0] S_BRAKE  = 4'd6;
    localparam logic [3:0] S_FINISH = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       go_reg, go_next;
    logic       accept;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        go_next = 1'b0;
        ctl = '0;
        ctl.div_sel = srmc_pkg::DSEL_STEPS;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctl.load_in = 1'b1;
                    if (in_cmd == srmc_pkg::CMD_TICK && cur_mode != srmc_pkg::MODE_STOP)
                    begin
                        state_next = S_STEPS;
                        go_next = 1'b1;
                    end
                    else
                        state_next = S_FINISH;
                end
            end
            S_STEPS, S_RAMP, S_LEFT, S_RIGHT, S_FREQ, S_BRAKE:
            begin
                unique case (state_reg)
                    S_STEPS: ctl.div_sel = srmc_pkg::DSEL_STEPS;
                    S_RAMP:  ctl.div_sel = srmc_pkg::DSEL_RAMP;
                    S_LEFT:  ctl.div_sel = srmc_pkg::DSEL_LEFT;
                    S_RIGHT: ctl.div_sel = srmc_pkg::DSEL_RIGHT;
                    S_FREQ:  ctl.div_sel = srmc_pkg::DSEL_FREQ;
                    default: ctl.div_sel = srmc_pkg::DSEL_BRAKE;
                endcase
                // braking step uses the constant reciprocal divide, not the divider
                ctl.div_start = go_reg && (state_reg != S_BRAKE);
                if (!go_reg && !stat.div_busy)
                begin
                    go_next = 1'b1;
                    unique case (state_reg)
                        S_STEPS: begin ctl.do_count = 1'b1; state_next = S_RAMP; end
                        S_RAMP:
                        begin
                            ctl.do_ramp = (cur_mode != srmc_pkg::MODE_RUN);
                            state_next = S_LEFT;
                        end
                        S_LEFT:  begin ctl.do_steer = 1'b1; state_next = S_RIGHT; end
                        S_RIGHT: begin ctl.do_steer = 1'b1; state_next = S_FREQ; end
                        S_FREQ:  begin ctl.do_brake_mul = 1'b1; state_next = S_BRAKE; end
                        default:
                        begin
                            ctl.do_brake = 1'b1;
                            go_next = 1'b0;
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_FINISH:
            begin
                ctl.do_finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            go_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg <= go_next;
        end
    end
endmodule
